### src/ucal_pkg.sv
package ucal_pkg;

  // Number of register stages between the input and the result port.
  localparam int unsigned NumStages = 6;

  typedef logic [NumStages-1:0] stage_en_t;

  localparam logic [3:0]  TzReset     = 4'd3;
  localparam logic [15:0] SecsPerHour = 16'd3600;
  localparam logic [11:0] EpochYear   = 12'd1970;
  localparam logic [8:0]  FebLastDay  = 9'd58;

  // Reciprocals for exact floor division by constants. Each one is
  // ceil(2^shift / divisor) with the shift chosen for the operand width.
  localparam logic [25:0] RecipDiv675  = 26'd50903317;  // x < 2^25, shift 35
  localparam logic [18:0] RecipDiv1461 = 19'd367469;    // x < 2^18, shift 29
  localparam logic [17:0] RecipDiv60   = 18'd139811;    // x < 2^17, shift 23
  localparam logic [13:0] RecipDiv367  = 14'd11429;     // x < 2^13, shift 22
  localparam logic [17:0] RecipDiv7    = 18'd149797;    // x < 2^17, shift 20

  // Floor of x / 60 for any 17-bit x below 122880 (the result is 11 bits).
  function automatic logic [10:0] div60(input logic [16:0] x);
    logic [34:0] prod;
    prod = {18'b0, x} * {17'b0, RecipDiv60};
    return prod[33:23];
  endfunction

  // First day of month (0-based) in the year with a 30-day February.
  function automatic logic [8:0] month_start(input logic [3:0] mon0);
    logic [8:0] start;
    unique case (mon0)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd61;
      4'd3:    start = 9'd92;
      4'd4:    start = 9'd122;
      4'd5:    start = 9'd153;
      4'd6:    start = 9'd183;
      4'd7:    start = 9'd214;
      4'd8:    start = 9'd245;
      4'd9:    start = 9'd275;
      4'd10:   start = 9'd306;
      4'd11:   start = 9'd336;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

### src/ucal_datapath.sv
module ucal_datapath
  import ucal_pkg::*;
(
  input  logic        clk,
  input  stage_en_t   stage_en,
  input  logic [3:0]  tz_hours,
  input  logic [31:0] unix_seconds,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [2:0]  day_of_week,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  // Stage 1: local time.
  logic [31:0] local1_r;
  logic [15:0] tz_secs;

  // Stage 2: day count.
  logic [24:0] q1_2_r;
  logic [6:0]  lo7_2_r;
  logic [15:0] days2_r;
  logic [50:0] prod675;

  // Stage 3: seconds of day, year count, weekday quotient.
  logic [16:0] sod3_r;
  logic [15:0] days3_r;
  logic [7:0]  years3_r;
  logic [16:0] wk3_r;
  logic [13:0] q7_3_r;
  logic [24:0] rem675;
  logic [17:0] ynum;
  logic [36:0] prod1461;
  logic [16:0] wkx;
  logic [34:0] prod7;

  // Stage 4: minutes of day, day of year, weekday.
  logic [16:0] sod4_r;
  logic [10:0] mod4_r;
  logic [8:0]  yday4_r;
  logic [7:0]  years4_r;
  logic [2:0]  dow4_r;
  logic [18:0] ystart;
  logic [15:0] ydiff;
  logic [16:0] wkr;

  // Stage 5: hour, second, adjusted day of year.
  logic [10:0] mod5_r;
  logic [4:0]  hour5_r;
  logic [5:0]  second5_r;
  logic [8:0]  yday5_r;
  logic [11:0] year5_r;
  logic [2:0]  dow5_r;
  logic [10:0] hq;
  logic [16:0] sec_full;
  logic        leap;
  logic [8:0]  yday_adj;

  // Stage 6: output registers.
  logic [11:0] year6_r;
  logic [3:0]  month6_r;
  logic [4:0]  mday6_r;
  logic [2:0]  dow6_r;
  logic [4:0]  hour6_r;
  logic [5:0]  minute6_r;
  logic [5:0]  second6_r;
  logic [12:0] mnum;
  logic [26:0] prod367;
  logic [3:0]  mon0;
  logic [8:0]  mday_full;
  logic [10:0] min_full;

  assign tz_secs = {12'b0, tz_hours} * SecsPerHour;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      local1_r <= unix_seconds + {16'b0, tz_secs};
    end
  end

  // 86400 = 128 * 675: the low seven bits pass straight to the remainder.
  assign prod675 = {26'b0, local1_r[31:7]} * {25'b0, RecipDiv675};

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      q1_2_r  <= local1_r[31:7];
      lo7_2_r <= local1_r[6:0];
      days2_r <= prod675[50:35];
    end
  end

  assign rem675   = q1_2_r - ({9'b0, days2_r} * 25'd675);
  assign ynum     = {days2_r, 2'b10};
  assign prod1461 = {19'b0, ynum} * {18'b0, RecipDiv1461};
  assign wkx      = {1'b0, days2_r} + 17'd4;
  assign prod7    = {18'b0, wkx} * {17'b0, RecipDiv7};

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      sod3_r   <= {rem675[9:0], lo7_2_r};
      days3_r  <= days2_r;
      years3_r <= prod1461[36:29];
      wk3_r    <= wkx;
      q7_3_r   <= prod7[33:20];
    end
  end

  assign ystart = ({11'b0, years3_r} * 19'd1461) + 19'd1;
  assign ydiff  = days3_r - ystart[17:2];
  assign wkr    = wk3_r - ({3'b0, q7_3_r} * 17'd7);

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      sod4_r   <= sod3_r;
      mod4_r   <= div60(sod3_r);
      yday4_r  <= ydiff[8:0];
      years4_r <= years3_r;
      dow4_r   <= wkr[2:0];
    end
  end

  assign hq       = div60({6'b0, mod4_r});
  assign sec_full = sod4_r - ({6'b0, mod4_r} * 17'd60);
  // Epoch year 1970 is 2 mod 4, so a leap year has years = 2 mod 4.
  assign leap     = (years4_r[1:0] == 2'd2);

  always_comb begin
    if (yday4_r > (FebLastDay + {8'b0, leap})) begin
      yday_adj = yday4_r + 9'd2 - {8'b0, leap};
    end else begin
      yday_adj = yday4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      mod5_r    <= mod4_r;
      hour5_r   <= hq[4:0];
      second5_r <= sec_full[5:0];
      yday5_r   <= yday_adj;
      year5_r   <= EpochYear + {4'b0, years4_r};
      dow5_r    <= dow4_r;
    end
  end

  assign mnum      = ({4'b0, yday5_r} * 13'd12) + 13'd6;
  assign prod367   = {14'b0, mnum} * {13'b0, RecipDiv367};
  assign mon0      = prod367[25:22];
  assign mday_full = yday5_r - month_start(mon0) + 9'd1;
  assign min_full  = mod5_r - ({6'b0, hour5_r} * 11'd60);

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      year6_r   <= year5_r;
      month6_r  <= mon0 + 4'd1;
      mday6_r   <= mday_full[4:0];
      dow6_r    <= dow5_r;
      hour6_r   <= hour5_r;
      minute6_r <= min_full[5:0];
      second6_r <= second5_r;
    end
  end

  assign year         = year6_r;
  assign month        = month6_r;
  assign day_of_month = mday6_r;
  assign day_of_week  = dow6_r;
  assign hour         = hour6_r;
  assign minute       = minute6_r;
  assign second       = second6_r;

endmodule

### src/unix_time_to_calendar_core.sv
// Channel | Direction | Ports
// in      | input     | in_valid, in_ready, in_unix_seconds
// out     | output    | out_valid, out_ready, out_year .. out_second
// cfg     | input     | cfg_valid, cfg_ready, cfg_tz_hours
//
// A six-stage pipeline accepts one item per cycle unless it is full and the output
// is stalled; each result passes through the stage registers in order and waits
// on the output until out_ready takes it.
// Reset (rst_n low, synchronous) empties the pipeline and sets tz_hours to 3.
// Each stage holds while the stage after it is full and stalled, so empty
// stages keep filling while a result waits at the output.
module unix_time_to_calendar_core
  import ucal_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_unix_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [2:0]  out_day_of_week,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_tz_hours
);

  logic [3:0] tz_r;
  logic [3:0] tz_nxt;
  stage_en_t  v_r;
  stage_en_t  v_nxt;
  stage_en_t  stage_rdy;

  assign cfg_ready = 1'b1;

  always_comb begin
    tz_nxt = tz_r;
    if (cfg_valid && cfg_ready) begin
      tz_nxt = cfg_tz_hours;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tz_r <= TzReset;
    end else begin
      tz_r <= tz_nxt;
    end
  end

  // A stage loads when it is empty or its contents move on this cycle.
  always_comb begin
    stage_rdy[NumStages-1] = !v_r[NumStages-1] || out_ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      stage_rdy[k] = !v_r[k] || stage_rdy[k+1];
    end
    v_nxt[0] = stage_rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k < NumStages; k++) begin
      v_nxt[k] = stage_rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = stage_rdy[0];
  assign out_valid = v_r[NumStages-1];

  ucal_datapath u_dp (
    .clk          (clk),
    .stage_en     (stage_rdy),
    .tz_hours     (tz_r),
    .unix_seconds (in_unix_seconds),
    .year         (out_year),
    .month        (out_month),
    .day_of_month (out_day_of_month),
    .day_of_week  (out_day_of_week),
    .hour         (out_hour),
    .minute       (out_minute),
    .second       (out_second)
  );

  // The pipeline only refuses input when every stage holds an item.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("input stalled with an empty stage");

  // Items are neither dropped nor duplicated inside the pipeline.
  a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 ($countones(v_r) == $countones($past(v_r))
         + int'($past(in_valid && in_ready))
         - int'($past(out_valid && out_ready))))
    else $error("pipeline item count mismatch");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1 && out_month <= 4'd12
                   && out_day_of_month >= 5'd1 && out_day_of_week <= 3'd6))
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour <= 5'd23 && out_minute <= 6'd59 && out_second <= 6'd59))
    else $error("time field out of range");

endmodule

### dv/tb_unix_time_to_calendar_core.sv
`timescale 1ns / 100ps

module tb_unix_time_to_calendar_core;
  import ucal_pkg::*;

  localparam int unsigned ItemsPerPhase = 250;
  localparam int unsigned HoldAtResult  = 400;
  localparam int unsigned HoldCycles    = 120;
  localparam int unsigned StallLimit    = 2000;

  typedef struct {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  day_of_week;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  class calendar_scoreboard;
    logic [3:0] tz_hours;
    calendar_t  pending_dates[$];
    int         mismatches;

    function new();
      tz_hours   = TzReset;
      mismatches = 0;
    endfunction

    function void set_tz(logic [3:0] value);
      tz_hours = value;
    endfunction

    function int pending();
      return pending_dates.size();
    endfunction

    // Julian leap rule, then a month lookup with February stretched to 30 days.
    function calendar_t to_calendar(logic [31:0] secs);
      logic [31:0] local_secs, days, sod, years, yr, yday, leap, mon0, mday;
      calendar_t   c;
      local_secs = secs + 32'd3600 * {28'd0, tz_hours};
      days  = local_secs / 32'd86400;
      sod   = local_secs % 32'd86400;
      years = (days * 32'd4 + 32'd2) / 32'd1461;
      yr    = 32'd1970 + years;
      yday  = days - (years * 32'd1461 + 32'd1) / 32'd4;
      leap  = (yr[1:0] == 2'd0) ? 32'd1 : 32'd0;
      if (yday > 32'd58 + leap) begin
        yday = yday + 32'd2 - leap;
      end
      mon0 = (yday * 32'd12 + 32'd6) / 32'd367;
      mday = yday - (mon0 * 32'd367 + 32'd5) / 32'd12 + 32'd1;
      c.year         = yr[11:0];
      c.month        = 4'(mon0 + 32'd1);
      c.day_of_month = mday[4:0];
      c.day_of_week  = 3'((32'd4 + days) % 32'd7);
      c.hour         = 5'(sod / 32'd3600);
      c.minute       = 6'((sod / 32'd60) % 32'd60);
      c.second       = 6'(sod % 32'd60);
      return c;
    endfunction

    function void note_input(logic [31:0] secs);
      pending_dates.push_back(to_calendar(secs));
    endfunction

    function void check_result(calendar_t got);
      calendar_t want;
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result %0d-%0d-%0d wd%0d %0d:%0d:%0d", $time,
                   got.year, got.month, got.day_of_month, got.day_of_week,
                   got.hour, got.minute, got.second);
        end
        return;
      end
      want = pending_dates.pop_front();
      if (got.year !== want.year || got.month !== want.month ||
          got.day_of_month !== want.day_of_month || got.day_of_week !== want.day_of_week ||
          got.hour !== want.hour || got.minute !== want.minute ||
          got.second !== want.second) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: expected %0d-%0d-%0d wd%0d %0d:%0d:%0d, got %0d-%0d-%0d wd%0d %0d:%0d:%0d",
                   $time, want.year, want.month, want.day_of_month, want.day_of_week,
                   want.hour, want.minute, want.second, got.year, got.month,
                   got.day_of_month, got.day_of_week, got.hour, got.minute, got.second);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_unix_seconds;
  logic        out_valid;
  logic        out_ready;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month;
  logic [2:0]  out_day_of_week;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_tz_hours;

  calendar_scoreboard sb;

  unix_time_to_calendar_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_unix_seconds  (in_unix_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_day_of_week  (out_day_of_week),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_tz_hours     (cfg_tz_hours)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // In every run of 160 items the last 40 have no gap, so both sides run without idling.
  function automatic int draw_gap(int idx);
    if ((idx / 40) % 4 == 3) begin
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  function automatic logic [31:0] draw_seconds();
    int unsigned sel;
    logic [31:0] day;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      return $urandom;
    end else if (sel < 7) begin
      day = $urandom_range(0, 49710);
      case ($urandom_range(0, 3))
        0:       return day * 32'd86400;
        1:       return day * 32'd86400 + 32'd86399;
        2:       return day * 32'd86400 - 32'd1;
        default: return day * 32'd86400 + $urandom_range(0, 86399);
      endcase
    end else if (sel == 7) begin
      // Close to the top of the range, where the zone offset wraps around.
      return 32'hFFFF_FFFF - $urandom_range(0, 60000);
    end else begin
      // Late February and early March of some year, around the leap day.
      day = ($urandom_range(0, 135) * 32'd1461 + 32'd1) / 32'd4 + $urandom_range(55, 62);
      return day * 32'd86400 + $urandom_range(0, 86399);
    end
  endfunction

  // All driving tasks are entered and left at a falling edge.
  task automatic send_seconds(input logic [31:0] secs, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_unix_seconds <= secs;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_tz(input logic [3:0] value);
    cfg_valid    <= 1'b1;
    cfg_tz_hours <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.set_tz(cfg_tz_hours);
      end
      if (in_valid && in_ready) begin
        sb.note_input(in_unix_seconds);
      end
      if (out_valid && out_ready) begin
        sb.check_result('{out_year, out_month, out_day_of_month, out_day_of_week,
                          out_hour, out_minute, out_second});
      end
    end
  end

  // Result side: random stalls, plus one long hold that backs the pipeline up.
  initial begin
    int n;
    int gap;
    n = 0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = (n == HoldAtResult) ? HoldCycles : draw_gap(n);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
      n++;
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_n === 1'b1);
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [31:0] directed[$];
    logic [3:0]  tz_plan[$];
    int          idx;
    sb              = new();
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_unix_seconds = '0;
    cfg_valid       = 1'b0;
    cfg_tz_hours    = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed items under the reset zone of three hours.
    directed = '{
      32'd0, 32'd1, 32'hFFFF_FFFF,
      32'hFFFF_FFFF - 32'd10799,  // local time wraps to exactly zero
      32'hFFFF_FFFF - 32'd10800,  // last second before the wrap
      32'd2667600,                // January 31 rolls into February 1
      32'd31449600,               // last day of 1970
      32'd68169600,               // leap day 1972
      32'd94694399,               // last UTC second of 1972, already 1973 locally
      32'd946674000,              // first second of 2000
      32'd951825600,              // leap day 2000
      32'd951868800,              // March 1 2000
      32'd2147483647, 32'd2147483648,
      32'd4107456000,             // February 28 2100
      32'd4107542400,             // leap day 2100 under the Julian rule
      32'd4107628800,             // March 1 2100, one day off Gregorian
      32'hAAAA_AAAA, 32'h5555_5555
    };
    foreach (directed[i]) begin
      send_seconds(directed[i], draw_gap(i));
    end
    drain_results();

    tz_plan = '{4'd0, 4'd14, 4'd15, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 14))};
    foreach (tz_plan[p]) begin
      write_tz(tz_plan[p]);
      for (idx = 0; idx < ItemsPerPhase; idx++) begin
        // Once, halfway through the second zone phase, the sender waits for the pipeline to empty.
        if (p == 1 && idx == ItemsPerPhase / 2) begin
          drain_results();
        end
        send_seconds(draw_seconds(), draw_gap(idx));
      end
      drain_results();
    end

    repeat (NumStages + 4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
